// ===== hdl/sorted_interval_table_defines.svh =====
// Assertion macros shared by the sorted interval table RTL.
`ifndef SORTED_INTERVAL_TABLE_DEFINES_SVH
`define SORTED_INTERVAL_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SIT_CHECK_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SIT_CHECK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/sit_pkg.sv =====
// Shared constants, types and helper functions of the sorted interval table.
`default_nettype none

package sit_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_BITS   = 48;
  localparam int LEN_W       = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W       = (ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W;

  localparam int TYPE_W = 2;
  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd2;

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERLAP = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam int IN_DATA_W  = ((ADDR_BITS + LEN_W) + 7) / 8 * 8;
  localparam int OUT_DATA_W = ((2 * IDX_W + ADDR_BITS + LEN_W) + 7) / 8 * 8;

  localparam int TREE_RADIX = 8;

  // Node count of a reduction level; level 0 is one leaf per cell.
  function automatic int nodes_at(input int level);
    int n;
    n = TABLE_DEPTH;
    for (int k = 0; k < level; k++) begin
      n = (n + TREE_RADIX - 1) / TREE_RADIX;
    end
    return n;
  endfunction

  function automatic int tree_levels();
    int n;
    int k;
    n = TABLE_DEPTH;
    k = 0;
    while (n > 1) begin
      n = (n + TREE_RADIX - 1) / TREE_RADIX;
      k++;
    end
    return k;
  endfunction

  localparam int TREE_LEVELS = tree_levels();

  // Request broadcast to every cell.
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [TYPE_W-1:0]    kind;
    logic [ADDR_BITS-1:0] addr;
    logic [LEN_W-1:0]     len;
    logic [IDX_W-1:0]     count;
  } sit_bcast_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [LEN_W-1:0]     len;
    logic                 right;
    logic                 lt;
  } sit_link_t;

  // One cell's contribution to the OR reduction; at most one cell drives each part.
  typedef struct packed {
    logic                 found;
    logic                 clash;
    logic [IDX_W-1:0]     idx;
    logic [ADDR_BITS-1:0] base;
    logic [LEN_W-1:0]     len;
  } sit_leaf_t;

  localparam sit_link_t LINK_FIRST = '{base: '0, len: '0, right: 1'b1, lt: 1'b1};
  localparam sit_link_t LINK_NONE  = '{base: '0, len: '0, right: 1'b0, lt: 1'b0};

endpackage

`default_nettype wire

// ===== hdl/sit_cell.sv =====
// One table slot: holds an interval, classifies it against the request, shifts on commit.
`default_nettype none

module sit_cell (
  input  wire logic               clk,
  input  wire logic [sit_pkg::IDX_W-1:0] index,
  input  wire sit_pkg::sit_bcast_t bcast,
  input  wire sit_pkg::sit_link_t  prev,
  input  wire sit_pkg::sit_link_t  next,
  output sit_pkg::sit_link_t       link,
  output sit_pkg::sit_leaf_t       leaf
);

  logic [sit_pkg::ADDR_BITS-1:0] base;
  logic [sit_pkg::LEN_W-1:0]     len;

  logic right_f;
  logic lt_f;
  logic hit_f;
  logic eq_f;
  logic gap_f;

  logic [sit_pkg::ADDR_BITS:0]   diff;
  logic [sit_pkg::ADDR_BITS-1:0] ahead;
  logic                          valid;
  logic                          above;
  logic                          covered;
  logic                          bnd;
  logic                          bndb;
  logic                          remove;

  // diff = addr - base with borrow in the top bit
  assign diff    = {1'b0, bcast.addr} - {1'b0, base};
  assign ahead   = base - bcast.addr;
  assign valid   = index < bcast.count;
  assign above   = !diff[sit_pkg::ADDR_BITS];
  assign covered = sit_pkg::CMP_W'(diff[sit_pkg::ADDR_BITS-1:0]) < sit_pkg::CMP_W'(len);

  always_ff @(posedge clk) begin
    right_f <= valid && above && !covered;
    hit_f   <= valid && above && covered;
    lt_f    <= valid && above && (diff[sit_pkg::ADDR_BITS-1:0] != '0);
    eq_f    <= valid && (diff == '0);
    gap_f   <= valid && (sit_pkg::CMP_W'(ahead) < sit_pkg::CMP_W'(bcast.len));
  end

  // first slot not passed by the cover search / by the base search
  assign bnd    = !right_f && prev.right;
  assign bndb   = !lt_f && prev.lt;
  assign remove = bcast.kind == sit_pkg::REQ_REMOVE;

  assign link.base  = base;
  assign link.len   = len;
  assign link.right = right_f;
  assign link.lt    = lt_f;

  assign leaf.found = remove ? (bndb && eq_f) : hit_f;
  assign leaf.clash = bnd && gap_f;
  assign leaf.idx   = (remove ? bndb : bnd) ? index : '0;
  assign leaf.base  = hit_f ? base : '0;
  assign leaf.len   = hit_f ? len : '0;

  always_ff @(posedge clk) begin
    unique case (bcast.op)
      sit_pkg::OP_INSERT: begin
        if (!right_f) begin
          if (bnd) begin
            base <= bcast.addr;
            len  <= bcast.len;
          end else begin
            base <= prev.base;
            len  <= prev.len;
          end
        end
      end
      sit_pkg::OP_REMOVE: begin
        if (!lt_f) begin
          base <= next.base;
          len  <= next.len;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sit_tree.sv =====
// Registered OR reduction of the per-cell leaves, one radix-8 level per cycle.
`default_nettype none

module sit_tree (
  input  wire logic               clk,
  input  wire sit_pkg::sit_leaf_t leaves [sit_pkg::TABLE_DEPTH],
  output sit_pkg::sit_leaf_t      root
);

  sit_pkg::sit_leaf_t node [sit_pkg::TREE_LEVELS+1][sit_pkg::TABLE_DEPTH];

  for (genvar j = 0; j < sit_pkg::TABLE_DEPTH; j++) begin : g_leaf
    assign node[0][j] = leaves[j];
  end

  for (genvar k = 1; k <= sit_pkg::TREE_LEVELS; k++) begin : g_level
    for (genvar j = 0; j < sit_pkg::TABLE_DEPTH; j++) begin : g_node
      if (j < sit_pkg::nodes_at(k)) begin : g_used
        sit_pkg::sit_leaf_t merged;
        always_comb begin
          merged = '0;
          for (int c = 0; c < sit_pkg::TREE_RADIX; c++) begin
            if (j * sit_pkg::TREE_RADIX + c < sit_pkg::nodes_at(k - 1)) begin
              merged = merged | node[k-1][j*sit_pkg::TREE_RADIX+c];
            end
          end
        end
        always_ff @(posedge clk) begin
          node[k][j] <= merged;
        end
      end else begin : g_unused
        assign node[k][j] = '0;
      end
    end
  end

  assign root = node[sit_pkg::TREE_LEVELS][0];

endmodule

`default_nettype wire

// ===== hdl/sorted_interval_table.sv =====
// Sorted interval table: top level with request sequencer, cell row and result register.
//
// Requests come in on the s_ stream: tuser carries the request type (insert,
// remove by exact base, lookup), tdata the address and length. Each request
// gives exactly one result on the m_ stream: tuser carries the status,
// tdata the index, the found base and length, and the entry count.
// The table is a row of TABLE_DEPTH cells, one interval each, kept sorted
// by base; an insert or remove moves every later cell one place at once.
// A request is classified by all cells at once; the per-cell outcomes are
// combined by a registered radix-8 OR tree (TREE_LEVELS levels, 4 at depth
// 1024), which sets the timing.
// One request is in work at a time; a new one is taken only once the last
// result has moved into the output register.
// A stalled result sits in the output register; the next request is still
// accepted and worked on, and its result waits until the register frees.
// Reset empties the table at once (count zero); no clearing pass is needed.
`default_nettype none
`include "sorted_interval_table_defines.svh"

module sorted_interval_table (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [sit_pkg::IN_DATA_W-1:0]    s_tdata,  // address, length
  input  wire logic [sit_pkg::TYPE_W-1:0]       s_tuser,  // req_type
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [sit_pkg::OUT_DATA_W-1:0]        m_tdata,  // entry_index, entry_base,
                                                          // entry_length, entry_count
  output logic [sit_pkg::ST_W-1:0]              m_tuser   // status
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EVAL   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_SEND   = 2'd3;

  localparam int WAIT_W = $clog2(sit_pkg::TREE_LEVELS + 1);

  logic [1:0]        state;
  logic [WAIT_W-1:0] wait_cnt;

  logic [sit_pkg::TYPE_W-1:0]    req_kind;
  logic [sit_pkg::ADDR_BITS-1:0] req_addr;
  logic [sit_pkg::LEN_W-1:0]     req_len;
  logic [sit_pkg::IDX_W-1:0]     held_count;
  logic [sit_pkg::IDX_W-1:0]     count_next;

  logic [sit_pkg::ST_W-1:0]      pend_status;
  logic [sit_pkg::IDX_W-1:0]     pend_idx;
  logic [sit_pkg::ADDR_BITS-1:0] pend_base;
  logic [sit_pkg::LEN_W-1:0]     pend_len;

  logic [sit_pkg::ST_W-1:0]      res_status;
  logic [sit_pkg::IDX_W-1:0]     res_idx;
  logic [sit_pkg::ADDR_BITS-1:0] res_base;
  logic [sit_pkg::LEN_W-1:0]     res_len;
  logic [sit_pkg::OP_W-1:0]      commit_op;

  logic accept;
  logic out_free;

  sit_pkg::sit_bcast_t bcast;
  sit_pkg::sit_link_t  links  [sit_pkg::TABLE_DEPTH];
  sit_pkg::sit_leaf_t  leaves [sit_pkg::TABLE_DEPTH];
  sit_pkg::sit_leaf_t  root;

  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign bcast.op    = (state == S_DECIDE) ? commit_op : sit_pkg::OP_HOLD;
  assign bcast.kind  = req_kind;
  assign bcast.addr  = req_addr;
  assign bcast.len   = req_len;
  assign bcast.count = held_count;

  for (genvar i = 0; i < sit_pkg::TABLE_DEPTH; i++) begin : g_cell
    sit_pkg::sit_link_t prev_link;
    sit_pkg::sit_link_t next_link;
    if (i == 0) begin : g_first
      assign prev_link = sit_pkg::LINK_FIRST;
    end else begin : g_mid_prev
      assign prev_link = links[i-1];
    end
    if (i == sit_pkg::TABLE_DEPTH - 1) begin : g_last
      assign next_link = sit_pkg::LINK_NONE;
    end else begin : g_mid_next
      assign next_link = links[i+1];
    end
    sit_cell u_cell (
      .clk   (clk),
      .index (sit_pkg::IDX_W'(i)),
      .bcast (bcast),
      .prev  (prev_link),
      .next  (next_link),
      .link  (links[i]),
      .leaf  (leaves[i])
    );
  end

  sit_tree u_tree (
    .clk    (clk),
    .leaves (leaves),
    .root   (root)
  );

  // Outcome of the request from the reduced cell flags.
  always_comb begin
    commit_op  = sit_pkg::OP_HOLD;
    res_status = sit_pkg::ST_MISSING;
    res_idx    = '0;
    res_base   = '0;
    res_len    = '0;
    count_next = held_count;
    unique case (req_kind)
      sit_pkg::REQ_INSERT: begin
        if (root.found || root.clash) begin
          res_status = sit_pkg::ST_OVERLAP;
        end else if (held_count == sit_pkg::IDX_W'(sit_pkg::TABLE_DEPTH)) begin
          res_status = sit_pkg::ST_FULL;
        end else begin
          res_status = sit_pkg::ST_OK;
          res_idx    = root.idx;
          commit_op  = sit_pkg::OP_INSERT;
          count_next = held_count + sit_pkg::IDX_W'(1);
        end
      end
      sit_pkg::REQ_REMOVE: begin
        if (root.found) begin
          res_status = sit_pkg::ST_OK;
          res_idx    = root.idx;
          commit_op  = sit_pkg::OP_REMOVE;
          count_next = held_count - sit_pkg::IDX_W'(1);
        end
      end
      sit_pkg::REQ_LOOKUP: begin
        if (root.found) begin
          res_status = sit_pkg::ST_OK;
          res_idx    = root.idx;
          res_base   = root.base;
          res_len    = root.len;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wait_cnt   <= '0;
      held_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_EVAL;
            wait_cnt <= '0;
          end
        end
        S_EVAL: begin
          // wait for the registered cell flags and for each registered tree level
          if (wait_cnt == WAIT_W'(sit_pkg::TREE_LEVELS)) begin
            state <= S_DECIDE;
          end else begin
            wait_cnt <= wait_cnt + WAIT_W'(1);
          end
        end
        S_DECIDE: begin
          held_count <= count_next;
          state      <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= s_tuser;
      req_addr <= s_tdata[sit_pkg::ADDR_BITS-1:0];
      req_len  <= s_tdata[sit_pkg::ADDR_BITS +: sit_pkg::LEN_W];
    end
    if (state == S_DECIDE) begin
      pend_status <= res_status;
      pend_idx    <= res_idx;
      pend_base   <= res_base;
      pend_len    <= res_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_SEND && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SEND && out_free) begin
      m_tuser <= pend_status;
      m_tdata <= sit_pkg::OUT_DATA_W'({held_count, pend_len, pend_base, pend_idx});
    end
  end

  `SIT_CHECK_NEXT(a_insert_grows, state == S_DECIDE && commit_op == sit_pkg::OP_INSERT, held_count == $past(held_count) + sit_pkg::IDX_W'(1), "insert did not grow the count")
  `SIT_CHECK_NEXT(a_remove_shrinks, state == S_DECIDE && commit_op == sit_pkg::OP_REMOVE, held_count == $past(held_count) - sit_pkg::IDX_W'(1), "remove did not shrink the count")
  `SIT_CHECK_NOW(a_remove_in_range, state == S_DECIDE && req_kind == sit_pkg::REQ_REMOVE && root.found, root.idx < held_count, "remove index beyond held entries")
  `SIT_CHECK_NOW(a_insert_slot, state == S_DECIDE && commit_op == sit_pkg::OP_INSERT, root.idx <= held_count, "insert slot beyond held entries")

endmodule

`default_nettype wire
